// ----- rtl/bsp_point_area_locator_core_macros.svh -----
// Assertion macros shared by the point area locator RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef BSP_POINT_AREA_LOCATOR_CORE_MACROS_SVH
`define BSP_POINT_AREA_LOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BSPL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BSPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSPL_ASSERT_SAME(label, ante, cons)
`define BSPL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/bspl_pkg.sv -----
// Package for the point area locator: sizes, codes and the command and status
// structs between controller and datapath. No dependencies.
package bspl_pkg;

  localparam int MAX_NODES    = 4096;
  localparam int MAX_AREAS    = 1024;
  localparam int MAX_STEPS    = 64;
  localparam int NODE_AW      = $clog2(MAX_NODES);
  localparam int COUNT_W      = 13;
  localparam int STEP_W       = $clog2(MAX_STEPS + 1);
  localparam int NORMAL_W     = 16;
  localparam int COORD_W      = 32;
  localparam int CHILD_W      = 13;
  localparam int AREA_W       = 11;
  localparam int PROD_W       = NORMAL_W + COORD_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int OFFSET_SHIFT = 14;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOCATE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_FOUND = 2'd0,
    STATUS_STEPS = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic signed [COORD_W-1:0]  plane_offset;
    logic signed [CHILD_W-1:0]  child_front;
    logic signed [CHILD_W-1:0]  child_back;
  } node_t;

  typedef struct packed {
    logic    wr;
    logic    load;
    logic    fetch;
    logic    mul;
    logic    sum;
    logic    advance;
    logic    emit;
    logic    area_leaf;
    status_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic beyond;
    logic leaf;
  } dp_stat_t;

endpackage

// ----- rtl/bspl_dpath.sv -----
// Datapath of the point area locator: node memory, count register, plane
// distance multiply and sum, node pointer and result registers. Uses bspl_pkg.
module bspl_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bspl_pkg::ctrl_cmd_t                 cmd,
  output bspl_pkg::dp_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [bspl_pkg::COUNT_W-1:0]        cfg_data,
  input  logic [bspl_pkg::NODE_AW-1:0]        in_node_index,
  input  logic signed [bspl_pkg::NORMAL_W-1:0] in_normal_x,
  input  logic signed [bspl_pkg::NORMAL_W-1:0] in_normal_y,
  input  logic signed [bspl_pkg::NORMAL_W-1:0] in_normal_z,
  input  logic signed [bspl_pkg::COORD_W-1:0] in_plane_offset,
  input  logic signed [bspl_pkg::CHILD_W-1:0] in_child_front,
  input  logic signed [bspl_pkg::CHILD_W-1:0] in_child_back,
  input  logic signed [bspl_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [bspl_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [bspl_pkg::COORD_W-1:0] in_point_z,
  output logic signed [bspl_pkg::AREA_W-1:0]  out_area,
  output logic [1:0]                          out_status
);

  bspl_pkg::node_t                      mem [bspl_pkg::MAX_NODES];
  bspl_pkg::node_t                      rd_r;
  logic [bspl_pkg::COUNT_W-1:0]         count_r;
  logic [bspl_pkg::COUNT_W-1:0]         count_eff;
  logic [bspl_pkg::NODE_AW-1:0]         node_r;
  logic signed [bspl_pkg::COORD_W-1:0]  px_r;
  logic signed [bspl_pkg::COORD_W-1:0]  py_r;
  logic signed [bspl_pkg::COORD_W-1:0]  pz_r;
  logic signed [bspl_pkg::PROD_W-1:0]   p0_r;
  logic signed [bspl_pkg::PROD_W-1:0]   p1_r;
  logic signed [bspl_pkg::PROD_W-1:0]   p2_r;
  logic signed [bspl_pkg::SUM_W-1:0]    plane_dist;
  logic                                 front;
  logic signed [bspl_pkg::CHILD_W-1:0]  child_r;
  logic signed [bspl_pkg::CHILD_W-1:0]  leaf_area;
  logic signed [bspl_pkg::AREA_W-1:0]   area_sat;
  logic signed [bspl_pkg::AREA_W-1:0]   area_r;
  logic [1:0]                           status_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[in_node_index] <= '{in_normal_x, in_normal_y, in_normal_z,
                              in_plane_offset, in_child_front, in_child_back};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_r <= mem[node_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  assign count_eff = (count_r > bspl_pkg::COUNT_W'(bspl_pkg::MAX_NODES)) ?
                     bspl_pkg::COUNT_W'(bspl_pkg::MAX_NODES) : count_r;

  // The plane distance is exact: each product is Q.14 and the offset is
  // scaled up to Q.14 before the sum.
  assign plane_dist = bspl_pkg::SUM_W'(p0_r) + bspl_pkg::SUM_W'(p1_r)
                    + bspl_pkg::SUM_W'(p2_r)
                    - (bspl_pkg::SUM_W'(rd_r.plane_offset) <<< bspl_pkg::OFFSET_SHIFT);
  assign front = !plane_dist[bspl_pkg::SUM_W-1] && (plane_dist != '0);

  // A leaf child c encodes area -c-1, which is the bitwise inverse of c.
  assign leaf_area = ~child_r;
  assign area_sat  = (leaf_area > bspl_pkg::CHILD_W'(bspl_pkg::MAX_AREAS - 1)) ?
                     bspl_pkg::AREA_W'(bspl_pkg::MAX_AREAS - 1) :
                     leaf_area[bspl_pkg::AREA_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r   <= in_point_x;
      py_r   <= in_point_y;
      pz_r   <= in_point_z;
      node_r <= '0;
    end else if (cmd.advance) begin
      node_r <= child_r[bspl_pkg::NODE_AW-1:0];
    end
    if (cmd.mul) begin
      p0_r <= bspl_pkg::PROD_W'(rd_r.normal_x) * bspl_pkg::PROD_W'(px_r);
      p1_r <= bspl_pkg::PROD_W'(rd_r.normal_y) * bspl_pkg::PROD_W'(py_r);
      p2_r <= bspl_pkg::PROD_W'(rd_r.normal_z) * bspl_pkg::PROD_W'(pz_r);
    end
    if (cmd.sum) begin
      child_r <= front ? rd_r.child_front : rd_r.child_back;
    end
    if (cmd.emit) begin
      area_r   <= cmd.area_leaf ? area_sat : '0;
      status_r <= cmd.code;
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.beyond     = (bspl_pkg::COUNT_W'(node_r) >= count_eff);
  assign stat.leaf       = child_r[bspl_pkg::CHILD_W-1] || (child_r == '0);

  assign out_area   = area_r;
  assign out_status = status_r;

endmodule

// ----- rtl/bspl_ctrl.sv -----
// Controller of the point area locator: walk sequencer, step counter and
// result strobe. Uses bspl_pkg and the assertion macro header.
`include "bsp_point_area_locator_core_macros.svh"
module bspl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_kind,
  input  bspl_pkg::dp_stat_t  stat,
  output bspl_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_SUM,
    ST_STEP
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [bspl_pkg::STEP_W-1:0] steps_r;
  logic [bspl_pkg::STEP_W-1:0] steps_nxt;
  logic                        strobe_r;
  logic                        accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd       = '0;
    cmd.code  = bspl_pkg::STATUS_FOUND;
    state_nxt = state_r;
    steps_nxt = steps_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == bspl_pkg::KIND_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (stat.count_zero) begin
              cmd.emit = 1'b1;
            end else begin
              steps_nxt = '0;
              state_nxt = ST_LOOK;
            end
          end
        end
      end
      ST_LOOK: begin
        if (steps_r == bspl_pkg::STEP_W'(bspl_pkg::MAX_STEPS)) begin
          cmd.emit  = 1'b1;
          cmd.code  = bspl_pkg::STATUS_STEPS;
          state_nxt = ST_IDLE;
        end else if (stat.beyond) begin
          cmd.emit  = 1'b1;
          cmd.code  = bspl_pkg::STATUS_RANGE;
          state_nxt = ST_IDLE;
        end else begin
          cmd.fetch = 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (stat.leaf) begin
          cmd.emit      = 1'b1;
          cmd.area_leaf = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      steps_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      steps_r  <= steps_nxt;
      strobe_r <= cmd.emit;
    end
  end

  assign out_valid = strobe_r;

  `BSPL_ASSERT_SAME(a_fetch_in_range, cmd.fetch,
                    !stat.beyond && (steps_r < bspl_pkg::STEP_W'(bspl_pkg::MAX_STEPS)))
  `BSPL_ASSERT_SAME(a_cmd_exclusive, 1'b1,
                    $onehot0({cmd.wr, cmd.fetch, cmd.mul, cmd.sum, cmd.advance, cmd.emit}))
  `BSPL_ASSERT_SAME(a_advance_not_leaf, cmd.advance, !stat.leaf)
  `BSPL_ASSERT_NEXT(a_emit_strobes, cmd.emit, out_valid && !busy)
  `BSPL_ASSERT_SAME(a_leaf_area_on_step, cmd.area_leaf, state_r == ST_STEP)

endmodule

// ----- rtl/bsp_point_area_locator_core.sv -----
// Point area locator top level. A locate query visits at most 64 nodes, and each level
// runs node memory read, multiply, sum and decision in that order. A walk ends on a leaf,
// on the step limit or on a node past the count; an empty table answers without a walk.
// Node writes give no result; one transaction is in flight at a time, and results
// cannot be stalled. Synchronous active-low reset clears the node count and sequencer.
module bsp_point_area_locator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic [11:0]                         in_node_index,
  input  logic signed [15:0]                  in_normal_x,
  input  logic signed [15:0]                  in_normal_y,
  input  logic signed [15:0]                  in_normal_z,
  input  logic signed [31:0]                  in_plane_offset,
  input  logic signed [12:0]                  in_child_front,
  input  logic signed [12:0]                  in_child_back,
  input  logic signed [31:0]                  in_point_x,
  input  logic signed [31:0]                  in_point_y,
  input  logic signed [31:0]                  in_point_z,
  output logic                                out_valid,
  output logic signed [10:0]                  out_area,
  output logic [1:0]                          out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [12:0]                         cfg_data
);

  bspl_pkg::ctrl_cmd_t cmd;
  bspl_pkg::dp_stat_t  stat;

  assign cfg_ready = !busy;

  bspl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bspl_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_node_index   (in_node_index),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_plane_offset (in_plane_offset),
    .in_child_front  (in_child_front),
    .in_child_back   (in_child_back),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .out_area        (out_area),
    .out_status      (out_status)
  );

endmodule

// ----- bench/bspl_area_checker.sv -----
`timescale 1ns / 1ps
// Checker for the point area locator: keeps its own node table and count, predicts
// the area and status of every locate query and compares each result strobe.
// Depends on bspl_pkg.
module bspl_area_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_kind,
  input  logic [11:0]         in_node_index,
  input  logic signed [15:0]  in_normal_x,
  input  logic signed [15:0]  in_normal_y,
  input  logic signed [15:0]  in_normal_z,
  input  logic signed [31:0]  in_plane_offset,
  input  logic signed [12:0]  in_child_front,
  input  logic signed [12:0]  in_child_back,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic signed [31:0]  in_point_z,
  input  logic                out_valid,
  input  logic signed [10:0]  out_area,
  input  logic [1:0]          out_status,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [12:0]         cfg_data,
  output int                  fail_count,
  output int                  areas_pending
);

  typedef struct packed {
    logic signed [bspl_pkg::AREA_W-1:0] area;
    bspl_pkg::status_t                  status;
  } area_result_t;

  bspl_pkg::node_t              plane_tab [bspl_pkg::MAX_NODES];
  logic [bspl_pkg::COUNT_W-1:0] live_count;
  area_result_t                 expected_areas [$];

  function automatic area_result_t locate_area(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
    area_result_t    res;
    bspl_pkg::node_t nd;
    longint          side_dist;
    int              limit;
    int              idx;
    int              child;
    int              steps;
    int              leaf_area;
    res.area   = '0;
    res.status = bspl_pkg::STATUS_FOUND;
    limit = (live_count > bspl_pkg::MAX_NODES) ? bspl_pkg::MAX_NODES : int'(live_count);
    if (limit == 0) return res;
    idx = 0;
    res.status = bspl_pkg::STATUS_STEPS;
    for (steps = 0; steps < bspl_pkg::MAX_STEPS; steps++) begin
      if (idx >= limit) begin
        res.status = bspl_pkg::STATUS_RANGE;
        break;
      end
      nd = plane_tab[idx];
      side_dist = longint'($signed(nd.normal_x)) * longint'(px)
                + longint'($signed(nd.normal_y)) * longint'(py)
                + longint'($signed(nd.normal_z)) * longint'(pz)
                - longint'($signed(nd.plane_offset)) * 64'sd16384;
      child = (side_dist > 0) ? $signed(nd.child_front) : $signed(nd.child_back);
      if (child <= 0) begin
        leaf_area = -child - 1;
        if (leaf_area > bspl_pkg::MAX_AREAS - 1) leaf_area = bspl_pkg::MAX_AREAS - 1;
        res.area   = leaf_area[bspl_pkg::AREA_W-1:0];
        res.status = bspl_pkg::STATUS_FOUND;
        break;
      end
      idx = child;
    end
    if (res.status != bspl_pkg::STATUS_FOUND) res.area = '0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    area_result_t want;
    if (!rst_n) begin
      live_count = '0;
      fail_count = 0;
      expected_areas.delete();
    end else begin
      if (out_valid) begin
        if (expected_areas.size() == 0) begin
          $error("result strobe with no locate transaction outstanding");
          fail_count++;
        end else begin
          want = expected_areas.pop_front();
          if (out_area !== want.area) begin
            $error("area: expected %0d, actual %0d", $signed(want.area), out_area);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) live_count = cfg_data;
      if (start && !busy) begin
        if (in_kind == bspl_pkg::KIND_WRITE) begin
          plane_tab[in_node_index] = {in_normal_x, in_normal_y, in_normal_z,
                                      in_plane_offset, in_child_front, in_child_back};
        end else begin
          expected_areas = {expected_areas,
                            locate_area(in_point_x, in_point_y, in_point_z)};
        end
      end
    end
    areas_pending = expected_areas.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the point area locator bench: clock, reset, node table loads, node count
// settings and locate queries. Depends on bspl_pkg, bspl_area_checker and the core.
module tb_top;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_kind;
  logic [11:0]        in_node_index;
  logic signed [15:0] in_normal_x;
  logic signed [15:0] in_normal_y;
  logic signed [15:0] in_normal_z;
  logic signed [31:0] in_plane_offset;
  logic signed [12:0] in_child_front;
  logic signed [12:0] in_child_back;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic signed [31:0] in_point_z;
  logic               out_valid;
  logic signed [10:0] out_area;
  logic [1:0]         out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [12:0]        cfg_data;
  int                 fail_count;
  int                 areas_pending;

  int cycles     = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  bsp_point_area_locator_core u_top (.*);

  bspl_area_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick == 0) begin
      case ($urandom_range(2, 0))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        default: return '0;
      endcase
    end
    if (pick < 4) return $urandom;
    return $urandom_range(32'h0010_0000, 0) - 32'h0008_0000;
  endfunction

  function automatic logic [15:0] rand_normal();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick == 0) begin
      case ($urandom_range(2, 0))
        0: return 16'h8000;
        1: return 16'h7FFF;
        default: return 16'h4000;
      endcase
    end
    if (pick < 5) return 16'($urandom);
    return 16'($urandom_range(32768, 0) - 16384);
  endfunction

  // Children are leaves, live nodes below n_nodes, or indexes at or past the
  // count, so a walk never reads an entry this phase has not loaded.
  function automatic logic [12:0] pick_child(input int n_nodes, input int eff,
                                             input int leaf_pct);
    int pick;
    pick = $urandom_range(99, 0);
    if (pick >= leaf_pct) begin
      if (pick < leaf_pct + 12 && eff < bspl_pkg::MAX_NODES)
        return 13'($urandom_range(bspl_pkg::MAX_NODES - 1, eff));
      if (n_nodes > 1) return 13'($urandom_range(n_nodes - 1, 1));
    end
    case ($urandom_range(9, 0))
      0: return 13'(0 - $urandom_range(4096, 0));
      1, 2: return 13'(0 - $urandom_range(1023, 0));
      default: return 13'(0 - $urandom_range(31, 0));
    endcase
  endfunction

  task automatic pace();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = $urandom_range(15, 0);
    end
  endtask

  task automatic issue();
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    pace();
  endtask

  task automatic load_node(input logic [11:0] idx, input logic [15:0] nx,
                           input logic [15:0] ny, input logic [15:0] nz,
                           input logic [31:0] off, input logic [12:0] front,
                           input logic [12:0] back);
    in_kind         <= bspl_pkg::KIND_WRITE;
    in_node_index   <= idx;
    in_normal_x     <= nx;
    in_normal_y     <= ny;
    in_normal_z     <= nz;
    in_plane_offset <= off;
    in_child_front  <= front;
    in_child_back   <= back;
    in_point_x      <= $urandom;
    in_point_y      <= $urandom;
    in_point_z      <= $urandom;
    issue();
  endtask

  task automatic locate_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz);
    in_kind         <= bspl_pkg::KIND_LOCATE;
    in_node_index   <= 12'($urandom);
    in_normal_x     <= 16'($urandom);
    in_normal_y     <= 16'($urandom);
    in_normal_z     <= 16'($urandom);
    in_plane_offset <= $urandom;
    in_child_front  <= 13'($urandom);
    in_child_back   <= 13'($urandom);
    in_point_x      <= px;
    in_point_y      <= py;
    in_point_z      <= pz;
    issue();
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (areas_pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(input logic [12:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic tree_phase(input int n_nodes, input logic [12:0] count,
                            input int n_items, input int leaf_pct);
    int eff;
    int k;
    set_count(count);
    eff = (count > bspl_pkg::MAX_NODES) ? bspl_pkg::MAX_NODES : int'(count);
    for (k = 0; k < n_nodes; k++) begin
      load_node(12'(k), rand_normal(), rand_normal(), rand_normal(), rand_coord(),
                pick_child(n_nodes, eff, leaf_pct), pick_child(n_nodes, eff, leaf_pct));
    end
    for (k = 0; k < n_items; k++) begin
      case ($urandom_range(19, 0))
        0: load_node(12'($urandom_range(n_nodes - 1, 0)), rand_normal(), rand_normal(),
                     rand_normal(), rand_coord(), pick_child(n_nodes, eff, leaf_pct),
                     pick_child(n_nodes, eff, leaf_pct));
        1: load_node(12'($urandom), rand_normal(), rand_normal(), rand_normal(),
                     rand_coord(), pick_child(n_nodes, eff, leaf_pct),
                     pick_child(n_nodes, eff, leaf_pct));
        default: locate_point(rand_coord(), rand_coord(), rand_coord());
      endcase
    end
  endtask

  initial begin : stimulus
    int          n_nodes;
    int          pick;
    logic [12:0] count;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_kind         <= bspl_pkg::KIND_WRITE;
    in_node_index   <= '0;
    in_normal_x     <= '0;
    in_normal_y     <= '0;
    in_normal_z     <= '0;
    in_plane_offset <= '0;
    in_child_front  <= '0;
    in_child_back   <= '0;
    in_point_x      <= '0;
    in_point_y      <= '0;
    in_point_z      <= '0;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table straight out of reset.
    locate_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);

    // Small hand-built tree: a zero leaf, a saturating leaf, a self loop and
    // a link past the count.
    set_count(13'd4);
    load_node(12'd0, 16'h4000, 16'h0, 16'h0, 32'h0, 13'd1, 13'd2);
    load_node(12'd1, 16'h0, 16'h0001, 16'h0, 32'h0, 13'd0, 13'(-1024));
    load_node(12'd2, 16'h0, 16'h0, 16'h4000, 32'h0005_0000, 13'd2, 13'd3);
    load_node(12'd3, 16'h8000, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 13'd4095, 13'(-4096));
    load_node(12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF);
    locate_point(32'd1, 32'd1, rand_coord());
    locate_point(32'd1, 32'd0, rand_coord());
    locate_point(32'd1, 32'h8000_0000, rand_coord());
    locate_point(32'd0, rand_coord(), 32'h0006_0000);
    locate_point(32'hFFFF_FFFF, 32'd0, 32'h0005_0000);
    locate_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    set_count(13'd4096);
    locate_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    set_count(13'd8191);
    locate_point(32'd1, 32'd1, rand_coord());
    set_count(13'd1);
    locate_point(32'd1, 32'd1, rand_coord());

    while (items_sent < 850) begin
      n_nodes = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
      pick = $urandom_range(19, 0);
      if (pick < 13) count = 13'(n_nodes);
      else if (pick < 16) count = 13'($urandom_range(n_nodes, 1));
      else if (pick < 18) count = 13'($urandom_range(8191, n_nodes));
      else if (pick == 18) count = $urandom_range(1, 0) ? 13'd4096 : 13'd8191;
      else count = '0;
      gaps_on = ($urandom_range(4, 0) != 0);
      tree_phase(n_nodes, count, $urandom_range(60, 20),
                 ($urandom_range(5, 0) == 0) ? 4 : 35);
    end

    wait_idle();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && areas_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
